[hdl/rpe_pkg.sv]
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared widths, constants and types of the pinhole reprojection error block.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int COEF_W  = 18;   // Q2.16 rotation coefficient
  localparam int POINT_W = 32;   // Q16.16 scene coordinate
  localparam int TRANS_W = 21;   // Q13.8 translation
  localparam int ACC_W   = 52;   // camera point with 32 fraction bits
  localparam int PROD_W  = COEF_W + POINT_W;
  localparam int CAM_W   = 36;   // camera point floored to 16 fraction bits
  localparam int ZMAG_W  = 35;   // depth magnitude
  localparam int FOCAL_W = 20;
  localparam int PIX_W   = 16;
  localparam int PROJ_W  = 18;
  localparam int ERR_W   = 17;
  localparam int SUM_W   = 32;
  localparam int NUM_W   = 58;   // divider dividend
  localparam int DEN_W   = 39;   // divider divisor
  localparam int QUO_W   = 19;   // divider quotient, saturating
  localparam int SQ_W    = 38;   // squared distance and root work registers
  localparam int DIFF_W  = 19;
  localparam int PV_W    = 21;
  localparam int FIFO_DEPTH = 2;
  localparam int CNT_W   = 17;   // point count, covers the largest point limit
  localparam int SEEN_W  = 11;   // points seen as reported on the result

  localparam int ROT_W  = 3 * COEF_W;
  localparam int TPK_W  = 3 * TRANS_W;
  localparam int PP_W   = 2 * PIX_W;
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_ROT_A = 3'd0;
  localparam logic [2:0] REG_ROT_B = 3'd1;
  localparam logic [2:0] REG_ROT_C = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_PRINC = 3'd5;

  localparam logic [ROT_W-1:0]   ROT_A_RST = 54'd65536;
  localparam logic [ROT_W-1:0]   ROT_B_RST = 54'd17179869184;
  localparam logic [ROT_W-1:0]   ROT_C_RST = 54'd4503599627370496;
  localparam logic [FOCAL_W-1:0] FOCAL_RST = 20'd371883;

  localparam logic signed [CAM_W-1:0] UNIT_DEPTH = 36'sd65536;
  localparam logic [ERR_W-1:0]        ERR_MAX    = '1;
  localparam logic signed [PV_W-1:0]  PROJ_HI    = 21'sd131071;
  localparam logic signed [PV_W-1:0]  PROJ_LO    = -21'sd131072;
  localparam logic [SQ_W-1:0]         ROOT_BIT0  = 38'h10_0000_0000; // 2^36

  typedef struct packed {
    logic [ROT_W-1:0]   rot_a;
    logic [ROT_W-1:0]   rot_b;
    logic [ROT_W-1:0]   rot_c;
    logic [TPK_W-1:0]   trans;
    logic [FOCAL_W-1:0] focal;
    logic [PP_W-1:0]    princ;
  } cfg_t;

  // classified point handed from front to back
  typedef struct packed {
    logic signed [CAM_W-1:0] cam_x;
    logic signed [CAM_W-1:0] cam_y;
    logic signed [CAM_W-1:0] cam_z;  // unit depth already substituted for zero
    logic                    behind;
    logic [PIX_W-1:0]        obs_u;
    logic [PIX_W-1:0]        obs_v;
    logic                    last;
  } job_t;

endpackage

[hdl/rpe_front.sv]
// ----------------------------------------------------------------------------
// rpe_front
// Accepts a point, forms the camera point R*p+T with one shared multiplier,
// flags depth, and hands the item to the job queue.
// ----------------------------------------------------------------------------
module rpe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpe_pkg::cfg_t                 cfg,
  input  logic                          push,
  output logic                          full,
  input  logic signed [rpe_pkg::POINT_W-1:0] point_x,
  input  logic signed [rpe_pkg::POINT_W-1:0] point_y,
  input  logic signed [rpe_pkg::POINT_W-1:0] point_z,
  input  logic [rpe_pkg::PIX_W-1:0]     obs_u,
  input  logic [rpe_pkg::PIX_W-1:0]     obs_v,
  input  logic                          last,
  output logic                          job_push,
  output rpe_pkg::job_t                 job,
  input  logic                          job_full
);
  import rpe_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MAC  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                    state_r, state_nxt;
  logic signed [POINT_W-1:0]  px_r, py_r, pz_r;
  logic [PIX_W-1:0]           obs_u_r, obs_v_r;
  logic                       last_r;
  logic [1:0]                 row_r, col_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [CAM_W-1:0]    cam_x_r, cam_y_r, cam_z_r;
  logic                       behind_r;

  logic [ROT_W-1:0]           row_bits;
  logic signed [COEF_W-1:0]   coef;
  logic signed [POINT_W-1:0]  pt;
  logic signed [TRANS_W-1:0]  tr;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc_base, acc_sum;
  logic signed [CAM_W-1:0]    cam_floor;

  // operand selection for the current row and column
  always_comb begin
    unique case (row_r)
      2'd0:    begin row_bits = cfg.rot_a; tr = cfg.trans[TRANS_W-1:0]; end
      2'd1:    begin row_bits = cfg.rot_b; tr = cfg.trans[2*TRANS_W-1:TRANS_W]; end
      default: begin row_bits = cfg.rot_c; tr = cfg.trans[3*TRANS_W-1:2*TRANS_W]; end
    endcase
    unique case (col_r)
      2'd0:    begin coef = row_bits[COEF_W-1:0];          pt = px_r; end
      2'd1:    begin coef = row_bits[2*COEF_W-1:COEF_W];   pt = py_r; end
      default: begin coef = row_bits[3*COEF_W-1:2*COEF_W]; pt = pz_r; end
    endcase
  end

  // multiply-accumulate, translation seeds each row
  assign prod      = coef * pt;
  assign acc_base  = (col_r == 2'd0) ? {{(ACC_W-TRANS_W-24){tr[TRANS_W-1]}}, tr, 24'b0} : acc_r;
  assign acc_sum   = acc_base + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign cam_floor = acc_sum[ACC_W-1:16];

  // sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (push) state_nxt = F_MAC;
      F_MAC:   if (row_r == 2'd2 && col_r == 2'd2) state_nxt = F_PUSH;
      F_PUSH:  if (!job_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE) begin
        row_r <= '0;
        col_r <= '0;
      end else if (state_r == F_MAC) begin
        if (col_r == 2'd2) begin
          col_r <= '0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
    end
  end

  // payload capture and camera point results
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && push) begin
      px_r    <= point_x;
      py_r    <= point_y;
      pz_r    <= point_z;
      obs_u_r <= obs_u;
      obs_v_r <= obs_v;
      last_r  <= last;
    end
    if (state_r == F_MAC) begin
      acc_r <= acc_sum;
      if (col_r == 2'd2) begin
        unique case (row_r)
          2'd0:    cam_x_r <= cam_floor;
          2'd1:    cam_y_r <= cam_floor;
          default: begin
            cam_z_r  <= (cam_floor == '0) ? UNIT_DEPTH : cam_floor;
            behind_r <= acc_sum[ACC_W-1] || (acc_sum == '0);
          end
        endcase
      end
    end
  end

  assign full     = (state_r != F_IDLE);
  assign job_push = (state_r == F_PUSH) && !job_full;

  always_comb begin
    job.cam_x  = cam_x_r;
    job.cam_y  = cam_y_r;
    job.cam_z  = cam_z_r;
    job.behind = behind_r;
    job.obs_u  = obs_u_r;
    job.obs_v  = obs_v_r;
    job.last   = last_r;
  end

endmodule

[hdl/rpe_fifo.sv]
// ----------------------------------------------------------------------------
// rpe_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module rpe_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  rpe_pkg::job_t wr_data,
  output logic          wr_full,
  input  logic          rd_en,
  output rpe_pkg::job_t rd_data,
  output logic          rd_empty
);
  import rpe_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  job_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign wr_full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign rd_empty = (count_r == '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && wr_full && !rd_en)) else $error("job queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && rd_empty)) else $error("job queue read while empty");
`endif

endmodule

[hdl/rpe_div.sv]
// ----------------------------------------------------------------------------
// rpe_div
// Shared restoring divider, one quotient bit per cycle; the quotient
// saturates to all ones when it does not fit.
// ----------------------------------------------------------------------------
module rpe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rpe_pkg::NUM_W-1:0]   num,
  input  logic [rpe_pkg::DEN_W-1:0]   den,
  output logic                        busy,
  output logic                        done,
  output logic [rpe_pkg::QUO_W-1:0]   quo
);
  import rpe_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic               busy_r, done_r;
  logic [STEP_W-1:0]  step_r;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic [QUO_W-1:0]   low_r, quo_r;
  logic               ovf;
  logic [DEN_W:0]     trial, diff;
  logic               take;

  assign ovf   = (num >= {den, {QUO_W{1'b0}}});
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= !ovf;
      done_r <= ovf;
      step_r <= STEP_W'(QUO_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath: one compare and subtract per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= num[NUM_W-1:QUO_W];
      low_r <= num[QUO_W-1:0];
      quo_r <= ovf ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hdl/rpe_back.sv]
// ----------------------------------------------------------------------------
// rpe_back
// Projects a queued camera point, measures the pixel error with a bit-serial
// root, keeps the running sum and count, and holds the result for the reader.
// ----------------------------------------------------------------------------
module rpe_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpe_pkg::cfg_t                     cfg,
  input  rpe_pkg::job_t                     job,
  input  logic                              job_empty,
  output logic                              job_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rpe_pkg::PROJ_W-1:0] projected_u,
  output logic signed [rpe_pkg::PROJ_W-1:0] projected_v,
  output logic                              behind_camera,
  output logic [rpe_pkg::ERR_W-1:0]         point_error,
  output logic [rpe_pkg::SUM_W-1:0]         error_total,
  output logic [rpe_pkg::ERR_W-1:0]         mean_error,
  output logic [rpe_pkg::SEEN_W-1:0]        points_seen,
  output logic                              last_out
);
  import rpe_pkg::*;

  typedef enum logic [9:0] {
    B_IDLE  = 10'b00_0000_0001,
    B_MULLO = 10'b00_0000_0010,
    B_MULHI = 10'b00_0000_0100,
    B_DIV   = 10'b00_0000_1000,
    B_SQU   = 10'b00_0001_0000,
    B_SQV   = 10'b00_0010_0000,
    B_ROOT  = 10'b00_0100_0000,
    B_ACC   = 10'b00_1000_0000,
    B_MEAN  = 10'b01_0000_0000,
    B_OUT   = 10'b10_0000_0000
  } bstate_t;

  localparam int MUL_W = FOCAL_W + 18;

  bstate_t                   state_r, state_nxt;
  job_t                      job_r;
  logic                      axis_r;
  logic [MUL_W-1:0]          plo_r;
  logic                      neg_r;
  logic signed [PROJ_W-1:0]  proj_u_r, proj_v_r;
  logic [SQ_W-1:0]           s_r, r_r, bit_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [ERR_W-1:0]          err_r, mean_r;
  logic [SUM_W-1:0]          total_r;
  logic [CNT_W-1:0]          seen_r;

  logic                      out_valid_r;
  logic signed [PROJ_W-1:0]  o_u_r, o_v_r;
  logic                      o_behind_r, o_last_r;
  logic [ERR_W-1:0]          o_err_r, o_mean_r;
  logic [SUM_W-1:0]          o_total_r;
  logic [SEEN_W-1:0]         o_seen_r;

  logic signed [CAM_W-1:0]   sel;
  logic [CAM_W-1:0]          mag, zabs;
  logic [ZMAG_W-1:0]         zmag;
  logic [MUL_W-1:0]          phi;
  logic [NUM_W-1:0]          proj_num, mean_num;
  logic [PIX_W-1:0]          center;
  logic signed [PV_W-1:0]    pv;
  logic signed [PROJ_W-1:0]  proj;
  logic signed [DIFF_W-1:0]  du, dv;
  logic signed [2*DIFF_W-1:0] sq_du, sq_dv;
  logic [SQ_W-1:0]           root_trial;
  logic [SQ_W-1:0]           err_wide;
  logic [ERR_W-1:0]          err;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_new;
  logic [CNT_W-1:0]          cnt_new;
  logic                      room;
  logic                      div_start, div_busy, div_done;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [QUO_W-1:0]          div_quo;
  logic                      out_load;

  // projection operands for the current axis
  assign sel      = axis_r ? job_r.cam_y : job_r.cam_x;
  assign mag      = sel[CAM_W-1] ? CAM_W'(-sel) : CAM_W'(sel);
  assign zabs     = job_r.cam_z[CAM_W-1] ? CAM_W'(-job_r.cam_z) : CAM_W'(job_r.cam_z);
  assign zmag     = zabs[ZMAG_W-1:0];
  assign phi      = cfg.focal * mag[CAM_W-1:18];
  assign proj_num = NUM_W'(plo_r) + NUM_W'({phi, 18'b0}) + NUM_W'({zmag, 3'b0});
  assign center   = axis_r ? cfg.princ[2*PIX_W-1:PIX_W] : cfg.princ[PIX_W-1:0];

  // center plus signed rounded offset, saturated
  always_comb begin
    pv = neg_r ? $signed({5'b0, center}) - $signed({2'b0, div_quo})
               : $signed({5'b0, center}) + $signed({2'b0, div_quo});
    if (pv > PROJ_HI)      proj = PROJ_HI[PROJ_W-1:0];
    else if (pv < PROJ_LO) proj = PROJ_LO[PROJ_W-1:0];
    else                   proj = pv[PROJ_W-1:0];
  end

  // pixel differences and squares
  assign du    = $signed({3'b0, job_r.obs_u}) - {proj_u_r[PROJ_W-1], proj_u_r};
  assign dv    = $signed({3'b0, job_r.obs_v}) - {proj_v_r[PROJ_W-1], proj_v_r};
  assign sq_du = du * du;
  assign sq_dv = dv * dv;

  // rounded root and accumulation
  assign root_trial = r_r + bit_r;
  assign err_wide   = (s_r > r_r) ? r_r + 1'b1 : r_r;
  assign err        = (err_wide > SQ_W'(ERR_MAX)) ? ERR_MAX : err_wide[ERR_W-1:0];
  assign room       = (cnt_r < CNT_W'(MAX_POINTS));
  assign sum_add    = {1'b0, sum_r} + (SUM_W+1)'(err);
  assign sum_new    = !room ? sum_r : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
  assign cnt_new    = room ? cnt_r + 1'b1 : cnt_r;
  assign mean_num   = NUM_W'(sum_new) + NUM_W'(cnt_new >> 1);

  // shared divider
  assign div_start = (state_r == B_MULHI) ||
                     (state_r == B_ACC && job_r.last && cnt_new != '0);
  assign div_num   = (state_r == B_ACC) ? mean_num : proj_num;
  assign div_den   = (state_r == B_ACC) ? DEN_W'(cnt_new) : {zmag, 4'b0};

  rpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_load = (state_r == B_OUT) && (!out_valid_r || pop);
  assign job_pop  = (state_r == B_IDLE) && !job_empty;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!job_empty) state_nxt = B_MULLO;
      B_MULLO: state_nxt = B_MULHI;
      B_MULHI: state_nxt = B_DIV;
      B_DIV:   if (div_done) state_nxt = axis_r ? B_SQU : B_MULLO;
      B_SQU:   state_nxt = B_SQV;
      B_SQV:   state_nxt = B_ROOT;
      B_ROOT:  if (bit_r[0]) state_nxt = B_ACC;
      B_ACC:   state_nxt = (job_r.last && cnt_new != '0) ? B_MEAN : B_OUT;
      B_MEAN:  if (div_done) state_nxt = B_OUT;
      B_OUT:   if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC) begin
        sum_r <= job_r.last ? '0 : sum_new;
        cnt_r <= job_r.last ? '0 : cnt_new;
      end
      if (out_load)      out_valid_r <= 1'b1;
      else if (pop)      out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r  <= job;
        axis_r <= 1'b0;
      end
      B_MULLO: plo_r <= cfg.focal * mag[17:0];
      B_MULHI: neg_r <= sel[CAM_W-1] ^ job_r.cam_z[CAM_W-1];
      B_DIV: begin
        if (div_done) begin
          if (axis_r) proj_v_r <= proj;
          else        proj_u_r <= proj;
          axis_r <= 1'b1;
        end
      end
      B_SQU: s_r <= SQ_W'(sq_du);
      B_SQV: begin
        s_r   <= s_r + SQ_W'(sq_dv);
        r_r   <= '0;
        bit_r <= ROOT_BIT0;
      end
      B_ROOT: begin
        if (s_r >= root_trial) begin
          s_r <= s_r - root_trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      B_ACC: begin
        err_r   <= err;
        total_r <= sum_new;
        seen_r  <= cnt_new;
        mean_r  <= '0;
      end
      B_MEAN: begin
        if (div_done) mean_r <= (div_quo > QUO_W'(ERR_MAX)) ? ERR_MAX : div_quo[ERR_W-1:0];
      end
      B_OUT: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_u_r      <= proj_u_r;
      o_v_r      <= proj_v_r;
      o_behind_r <= job_r.behind;
      o_err_r    <= err_r;
      o_total_r  <= total_r;
      o_mean_r   <= mean_r;
      o_seen_r   <= seen_r[SEEN_W-1:0];
      o_last_r   <= job_r.last;
    end
  end

  assign empty         = !out_valid_r;
  assign projected_u   = o_u_r;
  assign projected_v   = o_v_r;
  assign behind_camera = o_behind_r;
  assign point_error   = o_err_r;
  assign error_total   = o_total_r;
  assign mean_error    = o_mean_r;
  assign points_seen   = o_seen_r;
  assign last_out      = o_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS)) else $error("point count beyond limit");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");
`endif

endmodule

[hdl/pinhole_reprojection_error.sv]
// ----------------------------------------------------------------------------
// pinhole_reprojection_error
// The back end sets the pace: its shared one-bit-a-cycle divider runs twice per
// point, once more for the mean on a last point, and its root is bit-serial;
// the front accepts a new point only once it has handed the last one on.
// Reset (rst_n low, synchronous) restores register defaults, empties the job
// queue and result register, and clears the error sum and point count.
// ----------------------------------------------------------------------------
module pinhole_reprojection_error #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic signed [31:0]                in_point_x,
  input  logic signed [31:0]                in_point_y,
  input  logic signed [31:0]                in_point_z,
  input  logic [15:0]                       in_observed_u,
  input  logic [15:0]                       in_observed_v,
  input  logic                              in_last_point,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [17:0]                out_projected_u,
  output logic signed [17:0]                out_projected_v,
  output logic                              out_behind_camera,
  output logic [16:0]                       out_point_error,
  output logic [31:0]                       out_error_total,
  output logic [16:0]                       out_mean_error,
  output logic [rpe_pkg::SEEN_W-1:0]        out_points_seen,
  output logic                              out_last_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpe_pkg::APB_AW-1:0]        paddr,
  input  logic [rpe_pkg::APB_DW-1:0]        pwdata,
  output logic [rpe_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import rpe_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;
  job_t       fj, bj;
  logic       fj_push, q_full, q_pop, q_empty;

  // configuration registers
  assign reg_idx = paddr[APB_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_a <= ROT_A_RST;
      cfg_r.rot_b <= ROT_B_RST;
      cfg_r.rot_c <= ROT_C_RST;
      cfg_r.trans <= '0;
      cfg_r.focal <= FOCAL_RST;
      cfg_r.princ <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROT_A: cfg_r.rot_a <= pwdata[ROT_W-1:0];
        REG_ROT_B: cfg_r.rot_b <= pwdata[ROT_W-1:0];
        REG_ROT_C: cfg_r.rot_c <= pwdata[ROT_W-1:0];
        REG_TRANS: cfg_r.trans <= pwdata[TPK_W-1:0];
        REG_FOCAL: cfg_r.focal <= pwdata[FOCAL_W-1:0];
        REG_PRINC: cfg_r.princ <= pwdata[PP_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ROT_A: prdata = APB_DW'(cfg_r.rot_a);
      REG_ROT_B: prdata = APB_DW'(cfg_r.rot_b);
      REG_ROT_C: prdata = APB_DW'(cfg_r.rot_c);
      REG_TRANS: prdata = APB_DW'(cfg_r.trans);
      REG_FOCAL: prdata = APB_DW'(cfg_r.focal);
      REG_PRINC: prdata = APB_DW'(cfg_r.princ);
      default:   prdata = '0;
    endcase
  end

  rpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .push     (push),
    .full     (full),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .obs_u    (in_observed_u),
    .obs_v    (in_observed_v),
    .last     (in_last_point),
    .job_push (fj_push),
    .job      (fj),
    .job_full (q_full)
  );

  rpe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fj_push),
    .wr_data  (fj),
    .wr_full  (q_full),
    .rd_en    (q_pop),
    .rd_data  (bj),
    .rd_empty (q_empty)
  );

  rpe_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job           (bj),
    .job_empty     (q_empty),
    .job_pop       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .projected_u   (out_projected_u),
    .projected_v   (out_projected_v),
    .behind_camera (out_behind_camera),
    .point_error   (out_point_error),
    .error_total   (out_error_total),
    .mean_error    (out_mean_error),
    .points_seen   (out_points_seen),
    .last_out      (out_last_out)
  );

endmodule

[verif/rpe_checker.sv]
// ----------------------------------------------------------------------------
// rpe_checker
// Watches the point and result queues of the reprojection error block,
// predicts each result from its own copy of the registers and the running
// error sum, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module rpe_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic signed [31:0]           in_point_x,
  input  logic signed [31:0]           in_point_y,
  input  logic signed [31:0]           in_point_z,
  input  logic [15:0]                  in_observed_u,
  input  logic [15:0]                  in_observed_v,
  input  logic                         in_last_point,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [17:0]           out_projected_u,
  input  logic signed [17:0]           out_projected_v,
  input  logic                         out_behind_camera,
  input  logic [16:0]                  out_point_error,
  input  logic [31:0]                  out_error_total,
  input  logic [16:0]                  out_mean_error,
  input  logic [10:0]                  out_points_seen,
  input  logic                         out_last_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rpe_pkg::APB_AW-1:0]   paddr,
  input  logic [rpe_pkg::APB_DW-1:0]   pwdata,
  output int                           fail_count,
  output int                           pending
);
  import rpe_pkg::*;

  localparam int MAX_PTS = 1024;

  typedef struct packed {
    logic signed [17:0] pu;
    logic signed [17:0] pv;
    logic               behind;
    logic [16:0]        err;
    logic [31:0]        total;
    logic [16:0]        mean;
    logic [10:0]        seen;
    logic               last;
  } pix_result_t;

  pix_result_t expected_q[$];
  cfg_t        shadow;
  logic [32:0] sum_acc;
  logic [10:0] cnt_acc;

  function automatic logic signed [127:0] cam_axis(logic [53:0] row,
      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
      logic [20:0] t);
    logic signed [127:0] acc;
    acc = $signed(row[17:0]) * x + $signed(row[35:18]) * y + $signed(row[53:36]) * z;
    acc = acc + $signed(t) * 128'sd16777216;
    return acc;
  endfunction

  // center + round(f*x/z), ties away from zero, saturated to 18 bits
  function automatic logic signed [127:0] project_axis(logic signed [127:0] x16,
      logic signed [127:0] z16, logic [15:0] center);
    logic signed [127:0] num, den, q, r;
    logic                neg;
    if (z16 == 0) z16 = 65536;
    num = $signed({108'd0, shadow.focal}) * x16;
    neg = (num < 0) != (z16 < 0);
    if (num < 0) num = -num;
    den = ((z16 < 0) ? -z16 : z16) * 16;
    q = (num + den / 2) / den;
    r = $signed({112'd0, center}) + (neg ? -q : q);
    if (r < -131072) r = -131072;
    if (r > 131071) r = 131071;
    return r;
  endfunction

  function automatic logic [63:0] rounded_root(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (s > r) ? r + 1 : r;
  endfunction

  function automatic pix_result_t predict_pixel_error();
    pix_result_t         res;
    logic signed [127:0] cx, cy, cz, u, v, du, dv;
    logic [63:0]         sq, err, mean;
    cx = cam_axis(shadow.rot_a, in_point_x, in_point_y, in_point_z, shadow.trans[20:0]);
    cy = cam_axis(shadow.rot_b, in_point_x, in_point_y, in_point_z, shadow.trans[41:21]);
    cz = cam_axis(shadow.rot_c, in_point_x, in_point_y, in_point_z, shadow.trans[62:42]);
    u = project_axis(cx >>> 16, cz >>> 16, shadow.princ[15:0]);
    v = project_axis(cy >>> 16, cz >>> 16, shadow.princ[31:16]);
    du = $signed({112'd0, in_observed_u}) - u;
    dv = $signed({112'd0, in_observed_v}) - v;
    sq = 64'(du * du + dv * dv);
    err = rounded_root(sq);
    if (err > 131071) err = 131071;
    if (cnt_acc < MAX_PTS) begin
      sum_acc = sum_acc + 33'(err);
      if (sum_acc > 33'hFFFF_FFFF) sum_acc = 33'hFFFF_FFFF;
      cnt_acc = cnt_acc + 1;
    end
    mean = 0;
    if (in_last_point && cnt_acc != 0) begin
      mean = (64'(sum_acc) + cnt_acc / 2) / cnt_acc;
      if (mean > 131071) mean = 131071;
    end
    res.pu = u[17:0];
    res.pv = v[17:0];
    res.behind = (cz <= 0);
    res.err = err[16:0];
    res.total = sum_acc[31:0];
    res.mean = mean[16:0];
    res.seen = cnt_acc;
    res.last = in_last_point;
    if (in_last_point) begin
      sum_acc = 0;
      cnt_acc = 0;
    end
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    pix_result_t e;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      shadow <= '{ROT_A_RST, ROT_B_RST, ROT_C_RST, '0, FOCAL_RST, '0};
      sum_acc = 0;
      cnt_acc = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_ROT_A: shadow.rot_a <= pwdata[53:0];
          REG_ROT_B: shadow.rot_b <= pwdata[53:0];
          REG_ROT_C: shadow.rot_c <= pwdata[53:0];
          REG_TRANS: shadow.trans <= pwdata[62:0];
          REG_FOCAL: shadow.focal <= pwdata[19:0];
          REG_PRINC: shadow.princ <= pwdata[31:0];
          default: ;
        endcase
      end
      // accepted point
      if (push && !full) expected_q.push_back(predict_pixel_error());
      // accepted result
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_projected_u !== e.pu) begin
            $error("projected_u exp %0d got %0d", e.pu, out_projected_u);
            errs++;
          end
          if (out_projected_v !== e.pv) begin
            $error("projected_v exp %0d got %0d", e.pv, out_projected_v);
            errs++;
          end
          if (out_behind_camera !== e.behind) begin
            $error("behind_camera exp %0d got %0d", e.behind, out_behind_camera);
            errs++;
          end
          if (out_point_error !== e.err) begin
            $error("point_error exp %0d got %0d", e.err, out_point_error);
            errs++;
          end
          if (out_error_total !== e.total) begin
            $error("error_total exp %0d got %0d", e.total, out_error_total);
            errs++;
          end
          if (out_mean_error !== e.mean) begin
            $error("mean_error exp %0d got %0d", e.mean, out_mean_error);
            errs++;
          end
          if (out_points_seen !== e.seen) begin
            $error("points_seen exp %0d got %0d", e.seen, out_points_seen);
            errs++;
          end
          if (out_last_out !== e.last) begin
            $error("last_out exp %0d got %0d", e.last, out_last_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives points and register settings into the reprojection error block with
// random gaps on both queues; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import rpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full, empty, pready;
  logic                pop = 1'b0;
  logic signed [31:0]  in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [15:0]         in_observed_u = '0, in_observed_v = '0;
  logic                in_last_point = 1'b0;
  logic signed [17:0]  out_projected_u, out_projected_v;
  logic                out_behind_camera, out_last_out;
  logic [16:0]         out_point_error, out_mean_error;
  logic [31:0]         out_error_total;
  logic [10:0]         out_points_seen;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  int                  fail_count, pending;
  int                  idle_cycles = 0;
  bit                  pop_hold = 1'b0;

  always #5 clk = ~clk;

  pinhole_reprojection_error i_dut (.*);

  rpe_checker i_checker (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
  endfunction

  // watchdog on cycles with no accepted item or register write
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, some stretches with pop held high
  initial begin
    int n;
    forever begin
      if (pop_hold) begin
        @(posedge clk) pop <= 1'b1;
      end else begin
        n = gap_len();
        repeat (n) @(posedge clk) pop <= 1'b0;
        @(posedge clk) pop <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk) penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_queue();
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] u, logic [15:0] v, logic last, int gap);
    repeat (gap) @(posedge clk) push <= 1'b0;
    @(posedge clk);
    push <= 1'b1;
    in_point_x <= x; in_point_y <= y; in_point_z <= z;
    in_observed_u <= u; in_observed_v <= v; in_last_point <= last;
    do @(posedge clk); while (full);
    push <= 1'b0;
  endtask

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 18'h10000;
      1: return 18'h30000;
      2: return 18'($urandom_range(0, 32767)) - 18'd16384;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [53:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // random point in a plausible scene, sometimes any bit pattern
  task automatic send_random_point(logic last);
    logic [31:0] x, y, z;
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else begin
      x = 32'($signed($urandom_range(0, 2000000))) - 32'sd1000000;
      y = 32'($signed($urandom_range(0, 2000000))) - 32'sd1000000;
      z = 32'($urandom_range(1, 4000000));
      if ($urandom_range(0, 9) == 0) z = -z;
    end
    send_point(x, y, z, 16'($urandom), 16'($urandom), last, gap_len());
  endtask

  task automatic random_config(bit extreme);
    if (extreme) begin
      reg_write(REG_ROT_A, '1);
      reg_write(REG_ROT_B, {18'h1FFFF, 18'h20000, 18'h1FFFF});
      reg_write(REG_ROT_C, {18'h20000, 18'h1FFFF, 18'h20000});
      reg_write(REG_TRANS, '1);
      reg_write(REG_FOCAL, 20'hFFFFF);
      reg_write(REG_PRINC, 32'hFFFF_FFFF);
    end else begin
      reg_write(REG_ROT_A, rand_row());
      reg_write(REG_ROT_B, rand_row());
      reg_write(REG_ROT_C, rand_row());
      reg_write(REG_TRANS, {$urandom, $urandom});
      reg_write(REG_FOCAL, 20'($urandom));
      reg_write(REG_PRINC, $urandom);
    end
  endtask

  initial begin
    int set_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, extremes, depth zero and negative
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'd0, 16'd0, 1'b0, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'hFFFF, 1'b0, 1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 16'h1234, 16'h4321, 1'b0, 0);
    send_point(32'h0001_0000, 32'h0, 32'h0000_8000, 16'd100, 16'd100, 1'b0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 16'd5, 16'd5, 1'b1, 0);
    send_point(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, 0);
    drain_queue();
    random_config(1'b1);
    send_point(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 1'b0, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'hFFFF, 1'b1, 0);
    drain_queue();
    reg_write(REG_ROT_A, '0); reg_write(REG_ROT_B, '0); reg_write(REG_ROT_C, '0);
    reg_write(REG_TRANS, '0); reg_write(REG_FOCAL, '0); reg_write(REG_PRINC, '0);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0, 16'h8000, 16'h8000, 1'b1, 0);
    drain_queue();
    // a set of eight points with full-scale errors, with pop always ready
    pop_hold = 1'b1;
    random_config(1'b1);
    for (int i = 0; i < 8; i++)
      send_point(32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 16'h0, 16'h0, i == 7, 0);
    drain_queue();
    pop_hold = 1'b0;

    // random sets under several settings
    for (int phase = 0; phase < 6; phase++) begin
      random_config(phase == 3);
      for (int s = 0; s < 12; s++) begin
        set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        for (int k = 0; k < set_len; k++) send_random_point(k == set_len - 1);
      end
      drain_queue();
    end

    // one long set under the reset rotation
    reg_write(REG_ROT_A, ROT_A_RST); reg_write(REG_ROT_B, ROT_B_RST);
    reg_write(REG_ROT_C, ROT_C_RST);
    for (int k = 0; k < 40; k++)
      send_point(32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
                 32'h0001_0000, 16'($urandom), 16'($urandom), k == 39, 0);
    drain_queue();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
